// ===== sv/utk_pkg.sv =====
// ----------------------------------------------------------------------------
// utk_pkg
// Shared widths, opcodes and UTF-8 constants for the keystroke translator.
// ----------------------------------------------------------------------------
package utk_pkg;

  localparam int OP_W      = 2;
  localparam int BYTE_W    = 8;
  localparam int CP_W      = 21;
  localparam int KEY_W     = 10;
  localparam int MCNT_W    = 3;
  localparam int NUM_MOD_FIELDS = 4;

  localparam int TABLE_ENTRIES_DEF = 512;
  localparam int MAX_HELD_MODS_DEF = 4;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_TEXT   = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_t;

  // UTF-8 framing constants.
  localparam logic [CP_W-1:0]   REPL_CP    = 21'h00FFFD;
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_TAG  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_TAG  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_TAG  = 8'hF0;
  localparam logic [BYTE_W-1:0] ASCII_LIM  = 8'h80;
  localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;
  localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0F;
  localparam logic [BYTE_W-1:0] LEAD4_BITS = 8'h07;

  // Outcome of decoding one text byte: up to two lookups plus the new
  // decoder state.
  typedef struct packed {
    logic [1:0]      n_look;
    logic [CP_W-1:0] cp_a;
    logic [CP_W-1:0] cp_b;
    logic [1:0]      pend;
    logic [CP_W-1:0] partial;
  } dec_t;

endpackage

// ===== sv/utk_in_if.sv =====
// ----------------------------------------------------------------------------
// utk_in_if
// Input channel: table appends, table clears and UTF-8 text bytes.
// ----------------------------------------------------------------------------
interface utk_in_if;
  import utk_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [BYTE_W-1:0] text_byte;
  logic [CP_W-1:0]   entry_codepoint;
  logic [KEY_W-1:0]  entry_key;
  logic [KEY_W-1:0]  entry_mod_first;
  logic [KEY_W-1:0]  entry_mod_second;
  logic [KEY_W-1:0]  entry_mod_third;
  logic [KEY_W-1:0]  entry_mod_fourth;
  logic [MCNT_W-1:0] entry_mod_count;

  modport source (
    output valid, opcode, text_byte, entry_codepoint, entry_key,
           entry_mod_first, entry_mod_second, entry_mod_third, entry_mod_fourth,
           entry_mod_count,
    input  ready
  );

  modport sink (
    input  valid, opcode, text_byte, entry_codepoint, entry_key,
           entry_mod_first, entry_mod_second, entry_mod_third, entry_mod_fourth,
           entry_mod_count,
    output ready
  );

endinterface

// ===== sv/utk_out_if.sv =====
// ----------------------------------------------------------------------------
// utk_out_if
// Result channel: one keystroke per transaction.
// ----------------------------------------------------------------------------
interface utk_out_if;
  import utk_pkg::*;

  logic              valid;
  logic              ready;
  logic [CP_W-1:0]   out_codepoint;
  logic [KEY_W-1:0]  tap_key;
  logic [KEY_W-1:0]  hold_first;
  logic [KEY_W-1:0]  hold_second;
  logic [KEY_W-1:0]  hold_third;
  logic [KEY_W-1:0]  hold_fourth;
  logic [MCNT_W-1:0] hold_count;
  logic              last_of_run;

  modport source (
    output valid, out_codepoint, tap_key, hold_first, hold_second, hold_third,
           hold_fourth, hold_count, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, out_codepoint, tap_key, hold_first, hold_second, hold_third,
           hold_fourth, hold_count, last_of_run,
    output ready
  );

endinterface

// ===== sv/utk_decode.sv =====
// ----------------------------------------------------------------------------
// utk_decode
// One-byte UTF-8 decoder step: new decoder state and the characters to look up.
// ----------------------------------------------------------------------------
module utk_decode (
  input  logic [utk_pkg::BYTE_W-1:0] byte_i,
  input  logic [1:0]                 pend_i,
  input  logic [utk_pkg::CP_W-1:0]   partial_i,
  output utk_pkg::dec_t              dec_o
);
  import utk_pkg::*;

  logic            lead_look;
  logic [CP_W-1:0] lead_cp;
  logic            lead_multi;
  logic [1:0]      lead_pend;
  logic [CP_W-1:0] lead_part;
  logic [CP_W-1:0] cont_part;
  logic [1:0]      cont_pend;

  // The byte taken as a lead byte, with a clean decoder.
  always_comb begin
    lead_look  = 1'b0;
    lead_cp    = '0;
    lead_multi = 1'b0;
    lead_pend  = 2'd0;
    lead_part  = '0;
    if (byte_i == '0) begin
      lead_look = 1'b0;
    end else if (byte_i < ASCII_LIM) begin
      lead_look = 1'b1;
      lead_cp   = CP_W'(byte_i);
    end else if ((byte_i & LEAD2_MASK) == LEAD2_TAG) begin
      lead_multi = 1'b1;
      lead_pend  = 2'd1;
      lead_part  = CP_W'(byte_i & LEAD2_BITS);
    end else if ((byte_i & LEAD3_MASK) == LEAD3_TAG) begin
      lead_multi = 1'b1;
      lead_pend  = 2'd2;
      lead_part  = CP_W'(byte_i & LEAD3_BITS);
    end else if ((byte_i & LEAD4_MASK) == LEAD4_TAG) begin
      lead_multi = 1'b1;
      lead_pend  = 2'd3;
      lead_part  = CP_W'(byte_i & LEAD4_BITS);
    end else begin
      lead_look = 1'b1;
      lead_cp   = REPL_CP;
    end
  end

  assign cont_part = {partial_i[CP_W-7:0], byte_i[5:0]};
  assign cont_pend = pend_i - 2'd1;

  always_comb begin
    dec_o         = '0;
    dec_o.pend    = pend_i;
    dec_o.partial = partial_i;
    if (pend_i != 2'd0) begin
      if ((byte_i & CONT_MASK) == CONT_TAG) begin
        dec_o.pend = cont_pend;
        if (cont_pend == 2'd0) begin
          dec_o.n_look  = 2'd1;
          dec_o.cp_a    = cont_part;
          dec_o.partial = '0;
        end else begin
          dec_o.partial = cont_part;
        end
      end else begin
        // Broken sequence: replacement first, then the byte starts over.
        dec_o.n_look  = 2'd1;
        dec_o.cp_a    = REPL_CP;
        dec_o.pend    = lead_pend;
        dec_o.partial = lead_multi ? lead_part : '0;
        if (lead_look) begin
          dec_o.n_look = 2'd2;
          dec_o.cp_b   = lead_cp;
        end
      end
    end else begin
      if (lead_look) begin
        dec_o.n_look = 2'd1;
        dec_o.cp_a   = lead_cp;
      end
      if (lead_multi) begin
        dec_o.pend    = lead_pend;
        dec_o.partial = lead_part;
      end
    end
  end

endmodule

// ===== sv/utf8_to_keystroke_translator_top.sv =====
// ----------------------------------------------------------------------------
// utf8_to_keystroke_translator_top
// UTF-8 text to keystroke translator with a character-to-keystroke table.
// ----------------------------------------------------------------------------
// The block keeps a table of up to TABLE_ENTRIES entries, each mapping a
// character to a key code to tap and up to four modifier codes to hold, and
// it decodes UTF-8 text one byte at a time. It works on one input transaction
// at a time and is not ready while busy. A table append, a table clear or an
// ignored opcode leaves the block idle and ready for the next transaction. A
// text byte is decoded in the cycle it is accepted; every character it
// completes is then looked up by a linear scan of the table through a single
// comparator, one entry per cycle, with the first match winning. A lookup
// ends early when it hits, and a byte that breaks a multi-byte sequence runs
// up to two lookups (the replacement character, then the byte itself when it
// stands alone); the block stays busy while the result channel stalls. The
// table is a single-port-read memory whose registered read port is what sets
// the one-entry-per-cycle scan. Entries beyond the fill count are never read,
// so the table needs no clearing pass after reset. A byte gives zero, one or
// two result transactions, and last_of_run marks the final one.
// ----------------------------------------------------------------------------
module utf8_to_keystroke_translator_top #(
  parameter int TABLE_ENTRIES = utk_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_HELD_MODS = utk_pkg::MAX_HELD_MODS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  utk_in_if.sink       in_chan,
  utk_out_if.source    out_chan
);
  import utk_pkg::*;

  // Modifier slots actually kept per entry.
  localparam int SLOTS = (MAX_HELD_MODS < NUM_MOD_FIELDS) ? MAX_HELD_MODS : NUM_MOD_FIELDS;
  localparam int AW    = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // Entry layout: count in the low bits, then the modifiers, the tap key and
  // the character on top.
  localparam int MOD_LSB = MCNT_W;
  localparam int KEY_LSB = MOD_LSB + SLOTS * KEY_W;
  localparam int CP_LSB  = KEY_LSB + KEY_W;
  localparam int ENT_W   = CP_LSB + CP_W;

  localparam logic [MCNT_W-1:0] SLOTS_C = MCNT_W'(SLOTS);
  localparam logic [CNT_W-1:0]  FULL_C  = CNT_W'(TABLE_ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_OUT
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  entry_count_r;
  logic [1:0]        pend_r;
  logic [CP_W-1:0]   partial_r;

  logic [CP_W-1:0]   cp_r;
  logic [CP_W-1:0]   cp_next_r;
  logic              second_r;
  logic              held_v_r;
  logic [ENT_W-1:0]  held_r;
  logic              cur_pend_r;
  logic [CNT_W-1:0]  idx_r;
  logic              rd_pend_r;
  logic [ENT_W-1:0]  rd_data_r;

  logic              out_valid_r;
  logic [ENT_W-1:0]  out_ent_r;
  logic              out_last_r;

  logic [ENT_W-1:0]  table_mem [TABLE_ENTRIES];

  dec_t              dec;
  logic              in_fire;
  logic              hit;
  logic              rd_en;
  logic              scan_done;
  logic              wr_en;
  logic [ENT_W-1:0]  wr_data;
  logic [MCNT_W-1:0] mod_cnt;
  logic [KEY_W-1:0]  mods_in [NUM_MOD_FIELDS];
  logic [KEY_W-1:0]  hold_out [NUM_MOD_FIELDS];

  utk_decode u_decode (
    .byte_i    (in_chan.text_byte),
    .pend_i    (pend_r),
    .partial_i (partial_r),
    .dec_o     (dec)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;

  // Appends beyond the table size are dropped.
  assign wr_en = in_fire && (opcode_t'(in_chan.opcode) == OP_APPEND) &&
                 (entry_count_r < FULL_C);

  // The modifier count is clamped to the slots that exist, and slots at or
  // beyond the count are stored as zero so they read back cleared.
  assign mod_cnt = (in_chan.entry_mod_count > SLOTS_C) ? SLOTS_C : in_chan.entry_mod_count;

  assign mods_in[0] = in_chan.entry_mod_first;
  assign mods_in[1] = in_chan.entry_mod_second;
  assign mods_in[2] = in_chan.entry_mod_third;
  assign mods_in[3] = in_chan.entry_mod_fourth;

  assign wr_data[MCNT_W-1:0]            = mod_cnt;
  assign wr_data[KEY_LSB +: KEY_W]      = in_chan.entry_key;
  assign wr_data[CP_LSB +: CP_W]        = in_chan.entry_codepoint;

  for (genvar g = 0; g < SLOTS; g++) begin : g_wr_mod
    assign wr_data[MOD_LSB + g * KEY_W +: KEY_W] =
      (MCNT_W'(g) < mod_cnt) ? mods_in[g] : '0;
  end

  // Scan: the comparator looks at the entry read last cycle while the next
  // address is issued. A hit stops the reads so the matching entry stays in
  // the read register.
  assign hit       = (state_r == S_SCAN) && rd_pend_r &&
                     (rd_data_r[CP_LSB +: CP_W] == cp_r);
  assign rd_en     = (state_r == S_SCAN) && !hit && (idx_r < entry_count_r);
  assign scan_done = (state_r == S_SCAN) && (hit || (!rd_pend_r && !rd_en));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[entry_count_r[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= table_mem[idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      entry_count_r <= '0;
      pend_r        <= 2'd0;
      partial_r     <= '0;
      second_r      <= 1'b0;
      held_v_r      <= 1'b0;
      cur_pend_r    <= 1'b0;
      idx_r         <= '0;
      rd_pend_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      out_last_r    <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            case (opcode_t'(in_chan.opcode))
              OP_APPEND: begin
                if (wr_en) begin
                  entry_count_r <= entry_count_r + CNT_W'(1);
                end
              end
              OP_CLEAR: begin
                entry_count_r <= '0;
              end
              OP_TEXT: begin
                pend_r    <= dec.pend;
                partial_r <= dec.partial;
                cp_r      <= dec.cp_a;
                cp_next_r <= dec.cp_b;
                second_r  <= (dec.n_look == 2'd2);
                held_v_r  <= 1'b0;
                idx_r     <= '0;
                rd_pend_r <= 1'b0;
                if (dec.n_look != 2'd0) begin
                  state_r <= S_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_SCAN: begin
          // No read is issued in the cycle a scan finishes, so this also
          // clears the pending-read flag for a following second lookup.
          rd_pend_r <= rd_en;
          if (rd_en) begin
            idx_r <= idx_r + CNT_W'(1);
          end
          if (scan_done) begin
            if (second_r) begin
              // First lookup of a broken sequence: park its result until the
              // second lookup tells whether it is the last of the run.
              held_v_r  <= hit;
              held_r    <= rd_data_r;
              cp_r      <= cp_next_r;
              second_r  <= 1'b0;
              idx_r     <= '0;
            end else if (held_v_r) begin
              out_ent_r   <= held_r;
              out_last_r  <= !hit;
              cur_pend_r  <= hit;
              out_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end else if (hit) begin
              out_ent_r   <= rd_data_r;
              out_last_r  <= 1'b1;
              cur_pend_r  <= 1'b0;
              out_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end

        S_OUT: begin
          if (out_chan.ready) begin
            if (cur_pend_r) begin
              out_ent_r  <= rd_data_r;
              out_last_r <= 1'b1;
              cur_pend_r <= 1'b0;
            end else begin
              out_valid_r <= 1'b0;
              state_r     <= S_IDLE;
            end
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  for (genvar g = 0; g < NUM_MOD_FIELDS; g++) begin : g_rd_mod
    if (g < SLOTS) begin : g_kept
      assign hold_out[g] = out_ent_r[MOD_LSB + g * KEY_W +: KEY_W];
    end else begin : g_absent
      assign hold_out[g] = '0;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.out_codepoint = out_ent_r[CP_LSB +: CP_W];
  assign out_chan.tap_key       = out_ent_r[KEY_LSB +: KEY_W];
  assign out_chan.hold_first    = hold_out[0];
  assign out_chan.hold_second   = hold_out[1];
  assign out_chan.hold_third    = hold_out[2];
  assign out_chan.hold_fourth   = hold_out[3];
  assign out_chan.hold_count    = out_ent_r[MCNT_W-1:0];
  assign out_chan.last_of_run   = out_last_r;

  // A new input transaction is never taken while a result is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_chan.ready && out_valid_r))
    else $error("input accepted while a result is pending");

  // The fill count never passes the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count_r <= FULL_C)
    else $error("table fill count out of range");

  // A result that is not the last of its run is followed at once by the last.
  a_run_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_chan.ready && !out_last_r) |=> (out_valid_r && out_last_r))
    else $error("run ended without a final result");

  // The scan only reads entries that have been written.
  a_read_filled: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (idx_r < entry_count_r))
    else $error("scan read beyond the filled entries");

endmodule
